@@ rtl/mtt_pkg.sv @@
`timescale 1ns / 1ps

package mtt_pkg;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_TAG   = 2'd1,
        KIND_ATTR  = 2'd2,
        KIND_VALUE = 2'd3
    } kind_t;

    // most results one byte can cause
    localparam int RES_PER_WORD = 3;
    localparam int PUSH_W       = $clog2(RES_PER_WORD + 1);

endpackage

@@ rtl/markup_tag_tokenizer.sv @@
`timescale 1ns / 1ps

// Markup tokenizer: one text byte per input word (with the following byte for
// "/>" lookahead), up to three token words per byte (a tag close with its open
// attribute and value, or an end-of-input flush). A byte is taken every cycle
// unless the input stalls; it is held in the input register, is decoded in a
// single pass against the tokenizer state, and its tokens are written together
// into an eight-entry output queue, from whose head the first token is shown.
// The output drains one token word per cycle while out_stall is low. The input
// stalls while fewer than three queue entries are free, so the sustained rate
// is one byte per cycle as long as the tokens average no more than one per byte
// and the output is not stalled. There is no start-up sweep; the block is ready right after reset.
module markup_tag_tokenizer #(
    parameter int MAX_TEXT_LEN = 65536,
    parameter int MAX_TOKENS   = 4096,
    localparam int POS_W  = $clog2(MAX_TEXT_LEN + 2),
    localparam int SLOT_W = $clog2(MAX_TOKENS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        ch,
    input  logic [7:0]        next_ch,
    input  logic              has_next,
    input  logic              in_valid,
    output logic              in_stall,
    output logic [1:0]        kind,
    output logic [SLOT_W-1:0] slot,
    output logic [POS_W-1:0]  start_pos,
    output logic [POS_W-1:0]  end_pos,
    output logic              end_known,
    output logic [7:0]        attr_count,
    output logic              has_value,
    output logic              last_of_run,
    output logic              overflow,
    output logic              out_valid,
    input  logic              out_stall
);
    import mtt_pkg::*;

    localparam int Q_DEPTH = 8;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  end_pos;
        logic              end_known;
        logic [7:0]        attr_count;
        logic              has_value;
        logic              last_of_run;
        logic              overflow;
    } tok_t;

    localparam int TOK_W = $bits(tok_t);

    logic [PUSH_W-1:0]                   push_cnt;
    logic [RES_PER_WORD-1:0][TOK_W-1:0]  push_data;
    logic                                room;
    logic [TOK_W-1:0]                    head_data;
    tok_t                                head;

    mtt_core #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN),
        .MAX_TOKENS   (MAX_TOKENS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .next_ch   (next_ch),
        .has_next  (has_next),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .room      (room),
        .push_cnt  (push_cnt),
        .push_data (push_data)
    );

    mtt_queue #(
        .WIDTH (TOK_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head_data (head_data)
    );

    assign head        = tok_t'(head_data);
    assign kind        = head.kind;
    assign slot        = head.slot;
    assign start_pos   = head.start_pos;
    assign end_pos     = head.end_pos;
    assign end_known   = head.end_known;
    assign attr_count  = head.attr_count;
    assign has_value   = head.has_value;
    assign last_of_run = head.last_of_run;
    assign overflow    = head.overflow;

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != '0) |-> room)
        else $error("token words written without queue room");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != '0) |=> out_valid)
        else $error("written tokens not presented");

    a_count_tag_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_TAG)) |-> (attr_count == 8'd0))
        else $error("attribute count on a non-tag token");

    a_end_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !end_known) |-> ((end_pos == '0) && (kind != KIND_TEXT)))
        else $error("unset end carries a position");

endmodule

@@ rtl/mtt_queue.sv @@
`timescale 1ns / 1ps

module mtt_queue #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 8,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [mtt_pkg::PUSH_W-1:0]                push_cnt,
    input  logic [mtt_pkg::RES_PER_WORD-1:0][WIDTH-1:0] push_data,
    output logic                                      room,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [WIDTH-1:0]                          head_data
);
    import mtt_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_idx [RES_PER_WORD];
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= CNT_W'(DEPTH - RES_PER_WORD));
    assign head_data = mem[rd_ptr_reg];

    always_comb
    begin
        logic [PTR_W:0] sum;
        for (int i = 0; i < RES_PER_WORD; i++)
        begin
            sum = {1'b0, wr_ptr_reg} + (PTR_W + 1)'(i);
            if (sum >= (PTR_W + 1)'(DEPTH))
            begin
                sum = sum - (PTR_W + 1)'(DEPTH);
            end
            wr_idx[i] = sum[PTR_W-1:0];
        end
        sum = {1'b0, wr_ptr_reg} + (PTR_W + 1)'(push_cnt);
        if (sum >= (PTR_W + 1)'(DEPTH))
        begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        wr_ptr_next = sum[PTR_W-1:0];
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg;
        end
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_PER_WORD; i++)
        begin
            if (PUSH_W'(i) < push_cnt)
            begin
                mem[wr_idx[i]] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/mtt_core.sv @@
`timescale 1ns / 1ps

module mtt_core #(
    parameter int MAX_TEXT_LEN = 65536,
    parameter int MAX_TOKENS   = 4096,
    localparam int POS_W   = $clog2(MAX_TEXT_LEN + 2),
    localparam int SLOT_W  = $clog2(MAX_TOKENS),
    localparam int SLOT_CW = $clog2(MAX_TOKENS + 1),
    localparam int TOK_W   = SLOT_W + 2 * POS_W + 14
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [7:0]                                ch,
    input  logic [7:0]                                next_ch,
    input  logic                                      has_next,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      room,
    output logic [mtt_pkg::PUSH_W-1:0]                push_cnt,
    output logic [mtt_pkg::RES_PER_WORD-1:0][TOK_W-1:0] push_data
);
    import mtt_pkg::*;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  end_pos;
        logic              end_known;
        logic [7:0]        attr_count;
        logic              has_value;
        logic              last_of_run;
        logic              overflow;
    } tok_t;

    typedef struct packed {
        logic              live;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  end_pos;
        logic              end_known;
        logic [7:0]        count;
        logic              has_value;
    } rec_t;

    typedef struct packed {
        logic name;
        logic aname;
        logic posteq;
        logic inval;
        logic quote;
        logic ovf;
        logic intag;
    } mode_t;

    typedef struct packed {
        logic               ovf;
        logic [SLOT_W-1:0]  slot;
        logic [SLOT_CW-1:0] nxt;
    } alloc_t;

    function automatic alloc_t alloc(logic [SLOT_CW-1:0] ns);
        alloc_t a;
        if (ns < SLOT_CW'(MAX_TOKENS))
        begin
            a.ovf  = 1'b0;
            a.slot = ns[SLOT_W-1:0];
            a.nxt  = ns + SLOT_CW'(1);
        end
        else
        begin
            a.ovf  = 1'b1;
            a.slot = SLOT_W'(MAX_TOKENS - 1);
            a.nxt  = ns;
        end
        return a;
    endfunction

    function automatic rec_t open_rec(logic [POS_W-1:0] st, logic [SLOT_W-1:0] s);
        rec_t r;
        r           = '0;
        r.live      = 1'b1;
        r.slot      = s;
        r.start_pos = st;
        return r;
    endfunction

    function automatic tok_t make_tok(kind_t k, rec_t r, logic ov);
        tok_t t;
        t.kind        = k;
        t.slot        = r.slot;
        t.start_pos   = r.start_pos;
        t.end_pos     = r.end_known ? r.end_pos : '0;
        t.end_known   = r.end_known;
        t.attr_count  = (k == KIND_TAG) ? r.count : 8'd0;
        t.has_value   = (k == KIND_ATTR) && r.has_value;
        t.last_of_run = 1'b0;
        t.overflow    = ov;
        return t;
    endfunction

    logic               in_valid_reg;
    logic [7:0]         ch_reg;
    logic [7:0]         next_ch_reg;
    logic               has_next_reg;
    logic               go;
    logic               accept;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SLOT_CW-1:0] slot_reg, slot_next;
    logic [POS_W-1:0]   ts_reg, ts_next;
    logic               skip_reg, skip_next;
    mode_t              mode_reg, mode_next;
    rec_t               tag_reg, tag_next;
    rec_t               attr_reg, attr_next;
    rec_t               val_reg, val_next;

    tok_t               res [RES_PER_WORD];
    logic [PUSH_W-1:0]  n;

    assign go       = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;
    assign push_cnt = n;

    always_comb
    begin
        logic [POS_W-1:0] idx;
        logic             sc;
        logic             ends;
        logic             keep_ovf;
        alloc_t           a;
        rec_t             txt;

        pos_next  = pos_reg;
        slot_next = slot_reg;
        ts_next   = ts_reg;
        skip_next = skip_reg;
        mode_next = mode_reg;
        tag_next  = tag_reg;
        attr_next = attr_reg;
        val_next  = val_reg;
        n         = '0;
        idx       = pos_reg;
        sc        = 1'b0;
        ends      = 1'b0;
        keep_ovf  = 1'b0;
        a         = '0;
        txt       = '0;
        for (int i = 0; i < RES_PER_WORD; i++)
        begin
            res[i] = '0;
        end

        if (go)
        begin
            if (skip_reg)
            begin
                skip_next = 1'b0;
                if (pos_reg < POS_W'(MAX_TEXT_LEN))
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    mode_next.ovf = 1'b1;
                end
            end
            else if (pos_reg >= POS_W'(MAX_TEXT_LEN))
            begin
                mode_next.ovf = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (!mode_reg.intag)
                begin
                    if (ch_reg == CH_LT)
                    begin
                        if (idx > ts_reg)
                        begin
                            a             = alloc(slot_next);
                            slot_next     = a.nxt;
                            mode_next.ovf = mode_next.ovf | a.ovf;
                            txt           = open_rec(ts_reg, a.slot);
                            txt.end_pos   = idx;
                            txt.end_known = 1'b1;
                            res[n]        = make_tok(KIND_TEXT, txt, mode_next.ovf);
                            n             = n + PUSH_W'(1);
                        end
                        a              = alloc(slot_next);
                        slot_next      = a.nxt;
                        keep_ovf       = mode_next.ovf | a.ovf;
                        tag_next       = open_rec(idx + POS_W'(1), a.slot);
                        mode_next      = '0;
                        mode_next.ovf  = keep_ovf;
                        mode_next.intag = 1'b1;
                        mode_next.name = 1'b1;
                    end
                end
                else
                begin
                    sc = (ch_reg == CH_SLASH) && has_next_reg && (next_ch_reg == CH_GT);
                    if ((ch_reg == CH_GT) || sc)
                    begin
                        if (!tag_next.end_known)
                        begin
                            tag_next.end_pos   = idx;
                            tag_next.end_known = 1'b1;
                        end
                        if (attr_next.live && !attr_next.end_known)
                        begin
                            attr_next.end_pos   = idx;
                            attr_next.end_known = 1'b1;
                        end
                        if (val_next.live && !val_next.end_known)
                        begin
                            val_next.end_pos   = idx;
                            val_next.end_known = 1'b1;
                        end
                        res[n] = make_tok(KIND_TAG, tag_next, mode_next.ovf);
                        n      = n + PUSH_W'(1);
                        if (attr_next.live)
                        begin
                            res[n] = make_tok(KIND_ATTR, attr_next, mode_next.ovf);
                            n      = n + PUSH_W'(1);
                        end
                        if (val_next.live)
                        begin
                            res[n] = make_tok(KIND_VALUE, val_next, mode_next.ovf);
                            n      = n + PUSH_W'(1);
                        end
                        tag_next      = '0;
                        attr_next     = '0;
                        val_next      = '0;
                        keep_ovf      = mode_next.ovf;
                        mode_next     = '0;
                        mode_next.ovf = keep_ovf;
                        ts_next       = idx + POS_W'(1);
                        if (sc)
                        begin
                            ts_next   = idx + POS_W'(2);
                            skip_next = 1'b1;
                        end
                    end
                    else if ((ch_reg == CH_EQ) && attr_next.live && !mode_next.posteq)
                    begin
                        attr_next.end_pos   = idx;
                        attr_next.end_known = 1'b1;
                        attr_next.has_value = 1'b1;
                        mode_next.aname     = 1'b0;
                        mode_next.posteq    = 1'b1;
                    end
                    else if (mode_next.name)
                    begin
                        if (ch_reg == CH_SPACE)
                        begin
                            mode_next.name     = 1'b0;
                            tag_next.end_pos   = idx;
                            tag_next.end_known = 1'b1;
                        end
                    end
                    else if (mode_next.aname)
                    begin
                        if (ch_reg == CH_SPACE)
                        begin
                            attr_next.end_pos   = idx;
                            attr_next.end_known = 1'b1;
                            mode_next.aname     = 1'b0;
                        end
                    end
                    else if (mode_next.posteq)
                    begin
                        if (mode_next.inval)
                        begin
                            ends = mode_next.quote ? (ch_reg == CH_QUOTE) : (ch_reg == CH_SPACE);
                            if (ends)
                            begin
                                mode_next.inval    = 1'b0;
                                mode_next.posteq   = 1'b0;
                                mode_next.quote    = 1'b0;
                                val_next.end_pos   = idx;
                                val_next.end_known = 1'b1;
                                res[n] = make_tok(KIND_VALUE, val_next, mode_next.ovf);
                                n      = n + PUSH_W'(1);
                                val_next.live      = 1'b0;
                            end
                            else if (!mode_next.quote && (ch_reg == CH_QUOTE))
                            begin
                                val_next.start_pos = idx + POS_W'(1);
                                mode_next.quote    = 1'b1;
                            end
                        end
                        else
                        begin
                            mode_next.inval = 1'b1;
                            a               = alloc(slot_next);
                            slot_next       = a.nxt;
                            mode_next.ovf   = mode_next.ovf | a.ovf;
                            val_next        = open_rec(idx, a.slot);
                        end
                    end
                    else
                    begin
                        if (attr_next.live)
                        begin
                            res[n] = make_tok(KIND_ATTR, attr_next, mode_next.ovf);
                            n      = n + PUSH_W'(1);
                        end
                        a               = alloc(slot_next);
                        slot_next       = a.nxt;
                        mode_next.ovf   = mode_next.ovf | a.ovf;
                        attr_next       = open_rec(idx, a.slot);
                        mode_next.aname = 1'b1;
                        if (tag_next.count != 8'hFF)
                        begin
                            tag_next.count = tag_next.count + 8'd1;
                        end
                    end
                end
            end

            // end of input: flush open tokens, then return to reset
            if (!has_next_reg)
            begin
                if (mode_next.intag)
                begin
                    res[n] = make_tok(KIND_TAG, tag_next, mode_next.ovf);
                    n      = n + PUSH_W'(1);
                    if (attr_next.live)
                    begin
                        res[n] = make_tok(KIND_ATTR, attr_next, mode_next.ovf);
                        n      = n + PUSH_W'(1);
                    end
                    if (val_next.live)
                    begin
                        res[n] = make_tok(KIND_VALUE, val_next, mode_next.ovf);
                        n      = n + PUSH_W'(1);
                    end
                end
                else if (pos_next > ts_next)
                begin
                    a             = alloc(slot_next);
                    mode_next.ovf = mode_next.ovf | a.ovf;
                    txt           = open_rec(ts_next, a.slot);
                    txt.end_pos   = pos_next;
                    txt.end_known = 1'b1;
                    res[n]        = make_tok(KIND_TEXT, txt, mode_next.ovf);
                    n             = n + PUSH_W'(1);
                end
                pos_next  = '0;
                slot_next = '0;
                ts_next   = '0;
                skip_next = 1'b0;
                mode_next = '0;
                tag_next  = '0;
                attr_next = '0;
                val_next  = '0;
            end
        end

        for (int i = 0; i < RES_PER_WORD; i++)
        begin
            res[i].last_of_run = (n != '0) && (PUSH_W'(i) == n - PUSH_W'(1));
            push_data[i]       = res[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            ch_reg       <= '0;
            next_ch_reg  <= '0;
            has_next_reg <= 1'b0;
            pos_reg      <= '0;
            slot_reg     <= '0;
            ts_reg       <= '0;
            skip_reg     <= 1'b0;
            mode_reg     <= '0;
            tag_reg      <= '0;
            attr_reg     <= '0;
            val_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
                ch_reg       <= ch;
                next_ch_reg  <= next_ch;
                has_next_reg <= has_next;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end
            pos_reg  <= pos_next;
            slot_reg <= slot_next;
            ts_reg   <= ts_next;
            skip_reg <= skip_next;
            mode_reg <= mode_next;
            tag_reg  <= tag_next;
            attr_reg <= attr_next;
            val_reg  <= val_next;
        end
    end

endmodule
